@@ rtl/bba_pkg.sv @@
// shared types, field widths and helpers for the buddy block allocator
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // field widths of the stream payloads
  localparam int unsigned ORDER_W    = 3;
  localparam int unsigned OWNER_W    = 16;
  localparam int unsigned SIZE_W     = 6;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // largest order a request can round up to
  localparam int unsigned ORDER_LIMIT = 6;

  // controller to datapath commands
  typedef struct packed {
    logic ld_item;   // latch a new request, clear the index
    logic rd_idx;    // read the list entry at the index
    logic rd_prev;   // read the list entry just below the index
    logic idx_inc;   // step the index up
    logic found;     // remember the hit position and its order
    logic sh_start;  // point the index at the end of the list
    logic sh_wr;     // move the entry read into the index slot, step down
    logic split;     // halve the block, add the free buddy behind it
    logic final_wr;  // write the chosen block with its owner
    logic out_ld;    // load a list result into the output stage
    logic res_ld;    // load an allocate result into the output stage
    logic res_ok;    // allocate outcome carried with res_ld
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_query;   // pending request is a list query
    logic fits;       // entry read is free and large enough
    logic at_end;     // index is on the last listed block
    logic can_split;  // chosen block is still too large
    logic sh_more;    // entries remain to move before the split slot
    logic out_free;   // output stage can take a result this cycle
  } dp_sts_t;

  // smallest order whose block holds the given number of units
  function automatic logic [ORDER_W-1:0] order_for(input logic [SIZE_W-1:0] units);
    logic [ORDER_W-1:0] k;
    k = ORDER_W'(ORDER_LIMIT);
    for (int i = ORDER_LIMIT; i >= 0; i--) begin
      if ((7'd1 << i) >= 7'(units)) begin
        k = ORDER_W'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/buddy_block_allocator.sv @@
// top level of the buddy block allocator: controller, datapath and checks
`timescale 1ns / 1ps
`default_nettype none

// Buddy block allocator. Memory of 2^total_order units is kept as an ordered
// list of power-of-two blocks, each with an owner (0 means free). An allocate
// request rounds request_size up to a power of two, takes the first free block
// in list order that is large enough, halves it until it has the wanted size
// (each free buddy is inserted right behind it) and records owner_id; it
// returns one result echoing the owner with alloc_ok, or alloc_ok low and no
// change when nothing fits. A query request returns one result per listed
// block with its owner, tlast on the final one. Writing total_order (values
// above MAX_ORDER saturate) restarts the list as one free block; write it only
// while no request is in flight. The list lives in a single-port memory with a
// registered read, and that port sets the pace. An allocate reads each entry it
// scans; each halving moves every entry behind the split point up one place
// before the free buddy is written; then the chosen block is written with its
// owner (skipped when nothing fits) and the result is loaded. A query reads
// and emits one listed block at a time, and any output stall holds the work.
// One request is worked at a time; the next is taken as soon as the last
// result is in the output register, even while that result still waits.
module buddy_block_allocator #(
  parameter int unsigned MAX_ORDER  = 5,
  parameter int unsigned OWNER_BITS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration: total_order
  input  wire                              cfg_we_i,
  input  wire  [bba_pkg::ORDER_W-1:0]      cfg_wdata_i,
  // request stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [bba_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // owner_id[15:0], request_size[21:16]
  input  wire                              s_axis_tuser,   // action: 0 allocate, 1 query
  // result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // block_count[5:0], block_owner[21:6],
                                                           // alloc_ok[22]
  output logic                             m_axis_tlast
);
  import bba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // state machine walks the list, datapath holds it
  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_dp #(
    .MAX_ORDER  (MAX_ORDER),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_query_i  (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // a request is worked before the next one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while previous one still in work");

  // the list is never modified while requests are being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(cmd.split || cmd.sh_wr || cmd.final_wr))
    else $error("list write while idle");

  // only query results come without tlast, and those always report ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tdata[22])
    else $error("non-final result without ok");

  // a halving step is only issued for a block larger than wanted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.split |-> sts.can_split)
    else $error("split of a block that is small enough");

endmodule

`default_nettype wire

@@ rtl/bba_ctrl.sv @@
// sequencing state machine for the buddy block allocator
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  bba_pkg::dp_sts_t    sts_i,
  output bba_pkg::dp_cmd_t    cmd_o
);
  import bba_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_S_RD      = 10'b00_0000_0010,
    ST_S_CHK     = 10'b00_0000_0100,
    ST_SPLIT_CHK = 10'b00_0000_1000,
    ST_SH_CHK    = 10'b00_0001_0000,
    ST_SH_WR     = 10'b00_0010_0000,
    ST_FINAL     = 10'b00_0100_0000,
    ST_DONE      = 10'b00_1000_0000,
    ST_Q_RD      = 10'b01_0000_0000,
    ST_Q_EMIT    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ok_q, ok_d;

  always_comb begin
    state_d    = state_q;
    ok_d       = ok_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d       = sts_i.in_query ? ST_Q_RD : ST_S_RD;
        end
      end
      ST_S_RD: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = ST_S_CHK;
      end
      ST_S_CHK: begin
        if (sts_i.fits) begin
          cmd_o.found = 1'b1;
          state_d     = ST_SPLIT_CHK;
        end else if (sts_i.at_end) begin
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_S_RD;
        end
      end
      ST_SPLIT_CHK: begin
        if (sts_i.can_split) begin
          cmd_o.sh_start = 1'b1;
          state_d        = ST_SH_CHK;
        end else begin
          state_d = ST_FINAL;
        end
      end
      ST_SH_CHK: begin
        if (sts_i.sh_more) begin
          cmd_o.rd_prev = 1'b1;
          state_d       = ST_SH_WR;
        end else begin
          cmd_o.split = 1'b1;
          state_d     = ST_SPLIT_CHK;
        end
      end
      ST_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = ST_SH_CHK;
      end
      ST_FINAL: begin
        cmd_o.final_wr = 1'b1;
        ok_d           = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.res_ok = ok_q;
          state_d      = ST_IDLE;
        end
      end
      ST_Q_RD: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = ST_Q_EMIT;
      end
      ST_Q_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          if (sts_i.at_end) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_Q_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bba_dp.sv @@
// block list memory, index registers and output stage of the buddy block allocator
`timescale 1ns / 1ps
`default_nettype none

module bba_dp #(
  parameter int unsigned MAX_ORDER  = 5,
  parameter int unsigned OWNER_BITS = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [bba_pkg::ORDER_W-1:0]          cfg_wdata_i,
  input  wire                                  in_query_i,
  input  wire  [bba_pkg::IN_DATA_W-1:0]        in_data_i,
  input  bba_pkg::dp_cmd_t                     cmd_i,
  output bba_pkg::dp_sts_t                     sts_o,
  input  wire                                  out_ready_i,
  output logic                                 out_valid_o,
  output logic [bba_pkg::OUT_DATA_W-1:0]       out_data_o,
  output logic                                 out_last_o
);
  import bba_pkg::*;

  localparam int unsigned DEPTH       = 1 << MAX_ORDER;
  localparam int unsigned IDX_W       = MAX_ORDER;
  localparam int unsigned CNT_W       = MAX_ORDER + 1;
  localparam int unsigned ENTRY_W     = ORDER_W + OWNER_BITS;
  localparam int unsigned OWN_EXT     = (OWNER_BITS > OWNER_W) ? OWNER_BITS : OWNER_W;
  localparam int unsigned CNT_EXT     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned RESET_ORDER = (MAX_ORDER < 5) ? MAX_ORDER : 5;

  // list entry: order in the top bits, owner below
  logic [ENTRY_W-1:0]    mem [DEPTH];
  logic [ENTRY_W-1:0]    rdata_q;
  logic [IDX_W-1:0]      raddr_q;

  logic [ORDER_W-1:0]    total_order_q;
  logic                  init_q;       // list is still the single fresh block
  logic [CNT_W-1:0]      total_q;
  logic [CNT_W-1:0]      idx_q;
  logic [IDX_W-1:0]      pos_q;
  logic [ORDER_W-1:0]    cur_q;
  logic [ORDER_W-1:0]    want_q;
  logic [OWNER_BITS-1:0] owner_q;

  logic                  out_valid_q;
  logic [COUNT_W-1:0]    out_count_q;
  logic [OWNER_W-1:0]    out_owner_q;
  logic                  out_ok_q;
  logic                  out_last_q;

  logic [ENTRY_W-1:0]    rd_eff;
  logic [ORDER_W-1:0]    rd_order;
  logic [OWNER_BITS-1:0] rd_owner;
  logic                  mem_we;
  logic [IDX_W-1:0]      waddr;
  logic [ENTRY_W-1:0]    wdata;
  logic                  mem_re;
  logic [IDX_W-1:0]      raddr;
  logic [CNT_W-1:0]      idx_prev;
  logic [CNT_W-1:0]      idx_next;
  logic [IDX_W-1:0]      pos_next;
  logic [ORDER_W-1:0]    cur_half;
  logic [OWN_EXT-1:0]    own_in_ext;
  logic [OWN_EXT-1:0]    own_out_ext;
  logic [CNT_EXT-1:0]    cnt_ext;
  logic                  at_end;

  // entry zero reads as the fresh block until it is first written
  assign rd_eff   = (init_q && (raddr_q == '0)) ? {total_order_q, OWNER_BITS'(0)} : rdata_q;
  assign rd_order = rd_eff[ENTRY_W-1 -: ORDER_W];
  assign rd_owner = rd_eff[OWNER_BITS-1:0];

  assign idx_prev = idx_q - CNT_W'(1);
  assign idx_next = idx_q + CNT_W'(1);
  assign pos_next = pos_q + IDX_W'(1);
  assign cur_half = cur_q - ORDER_W'(1);
  assign at_end   = (idx_next == total_q);

  always_comb begin
    mem_we = 1'b0;
    waddr  = pos_q;
    wdata  = {cur_q, owner_q};
    if (cmd_i.sh_wr) begin
      mem_we = 1'b1;
      waddr  = idx_q[IDX_W-1:0];
      wdata  = rd_eff;
    end else if (cmd_i.split) begin
      mem_we = 1'b1;
      waddr  = pos_next;
      wdata  = {cur_half, OWNER_BITS'(0)};
    end else if (cmd_i.final_wr) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = cmd_i.rd_idx | cmd_i.rd_prev;
  assign raddr  = cmd_i.rd_prev ? idx_prev[IDX_W-1:0] : idx_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
      raddr_q <= raddr;
    end
  end

  assign own_in_ext  = OWN_EXT'(in_data_i[OWNER_W-1:0]);
  assign own_out_ext = OWN_EXT'(cmd_i.out_ld ? rd_owner : owner_q);
  assign cnt_ext     = CNT_EXT'(total_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_order_q <= ORDER_W'(RESET_ORDER);
      init_q        <= 1'b1;
      total_q       <= CNT_W'(1);
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        total_order_q <= (cfg_wdata_i > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                              : cfg_wdata_i;
        init_q        <= 1'b1;
        total_q       <= CNT_W'(1);
      end else begin
        if (mem_we && (waddr == '0)) begin
          init_q <= 1'b0;
        end
        if (cmd_i.split) begin
          total_q <= total_q + CNT_W'(1);
        end
      end

      if (cmd_i.ld_item) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_next;
      end else if (cmd_i.sh_start) begin
        idx_q <= total_q;
      end else if (cmd_i.sh_wr) begin
        idx_q <= idx_prev;
      end

      if (cmd_i.out_ld || cmd_i.res_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      want_q  <= order_for(in_data_i[OWNER_W +: SIZE_W]);
      owner_q <= own_in_ext[OWNER_BITS-1:0];
    end
    if (cmd_i.found) begin
      pos_q <= idx_q[IDX_W-1:0];
      cur_q <= rd_order;
    end else if (cmd_i.split) begin
      cur_q <= cur_half;
    end
    if (cmd_i.out_ld || cmd_i.res_ld) begin
      out_count_q <= cnt_ext[COUNT_W-1:0];
      out_owner_q <= own_out_ext[OWNER_W-1:0];
      out_ok_q    <= cmd_i.out_ld | cmd_i.res_ok;
      out_last_q  <= cmd_i.res_ld | at_end;
    end
  end

  assign sts_o.in_query  = in_query_i;
  assign sts_o.fits      = (rd_owner == '0) && (rd_order >= want_q);
  assign sts_o.at_end    = at_end;
  assign sts_o.can_split = (cur_q > want_q) && (total_q < CNT_W'(DEPTH));
  assign sts_o.sh_more   = idx_q > CNT_W'({1'b0, pos_q} + CNT_W'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {1'b0, out_ok_q, out_owner_q, out_count_q};
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

@@ tb/tb_buddy_block_allocator.sv @@
// self-checking testbench for the buddy block allocator
`timescale 1ns / 1ps

module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int unsigned LIST_CAP       = 32;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned CFG_SETTLE     = 8;
  localparam int unsigned END_SETTLE     = 400;
  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned PHASE_ITEMS    = 22;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ROW_ALLOC,
    ROW_QUERY,
    ROW_CFG
  } row_kind_e;

  // one beat of the result stream
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [OWNER_W-1:0] owner;
    logic               ok;
    logic               last;
  } reply_t;

  // directed stimulus row; typed rows carry their single result
  typedef struct packed {
    row_kind_e          kind;
    logic [OWNER_W-1:0] owner;
    logic [SIZE_W-1:0]  size;
    logic [ORDER_W-1:0] order;
    logic               typed;
    logic [COUNT_W-1:0] t_count;
    logic [OWNER_W-1:0] t_owner;
    logic               t_ok;
  } row_t;

  localparam int unsigned NUM_ROWS = 23;
  localparam row_t DIRECTED [0:NUM_ROWS-1] = '{
    // fresh list after reset: one free block
    '{ROW_QUERY, 16'h0000, 6'd0,  3'd0, 1'b1, 6'd1, 16'h0000, 1'b1},
    // size field at its top and just above the memory: refused, no change
    '{ROW_ALLOC, 16'hFFFF, 6'd63, 3'd0, 1'b1, 6'd1, 16'hFFFF, 1'b0},
    '{ROW_ALLOC, 16'h1234, 6'd33, 3'd0, 1'b1, 6'd1, 16'h1234, 1'b0},
    // whole memory in one go, then nothing left
    '{ROW_ALLOC, 16'h0001, 6'd32, 3'd0, 1'b1, 6'd1, 16'h0001, 1'b1},
    '{ROW_ALLOC, 16'h0002, 6'd1,  3'd0, 1'b1, 6'd1, 16'h0002, 1'b0},
    '{ROW_QUERY, 16'h0000, 6'd0,  3'd0, 1'b1, 6'd1, 16'h0001, 1'b1},
    '{ROW_CFG,   16'h0000, 6'd0,  3'd5, 1'b0, 6'd0, 16'h0000, 1'b0},
    // zero size rounds to one unit and splits all the way down
    '{ROW_ALLOC, 16'h00AA, 6'd0,  3'd0, 1'b0, 6'd0, 16'h0000, 1'b0},
    // owner zero leaves the block free
    '{ROW_ALLOC, 16'h0000, 6'd1,  3'd0, 1'b0, 6'd0, 16'h0000, 1'b0},
    '{ROW_ALLOC, 16'h5555, 6'd2,  3'd0, 1'b0, 6'd0, 16'h0000, 1'b0},
    '{ROW_ALLOC, 16'hAAAA, 6'd3,  3'd0, 1'b0, 6'd0, 16'h0000, 1'b0},
    '{ROW_ALLOC, 16'h8000, 6'd5,  3'd0, 1'b0, 6'd0, 16'h0000, 1'b0},
    '{ROW_ALLOC, 16'h7FFF, 6'd16, 3'd0, 1'b0, 6'd0, 16'h0000, 1'b0},
    '{ROW_ALLOC, 16'h0100, 6'd4,  3'd0, 1'b0, 6'd0, 16'h0000, 1'b0},
    '{ROW_QUERY, 16'h0000, 6'd0,  3'd0, 1'b0, 6'd0, 16'h0000, 1'b0},
    // order above the maximum saturates
    '{ROW_CFG,   16'h0000, 6'd0,  3'd7, 1'b0, 6'd0, 16'h0000, 1'b0},
    '{ROW_ALLOC, 16'h0042, 6'd31, 3'd0, 1'b1, 6'd1, 16'h0042, 1'b1},
    // smallest memory: a single unit
    '{ROW_CFG,   16'h0000, 6'd0,  3'd0, 1'b0, 6'd0, 16'h0000, 1'b0},
    '{ROW_ALLOC, 16'h0003, 6'd1,  3'd0, 1'b1, 6'd1, 16'h0003, 1'b1},
    '{ROW_ALLOC, 16'h0004, 6'd2,  3'd0, 1'b1, 6'd1, 16'h0004, 1'b0},
    '{ROW_QUERY, 16'h0000, 6'd0,  3'd0, 1'b1, 6'd1, 16'h0003, 1'b1},
    '{ROW_CFG,   16'h0000, 6'd0,  3'd6, 1'b0, 6'd0, 16'h0000, 1'b0},
    '{ROW_ALLOC, 16'hFFFF, 6'd63, 3'd0, 1'b1, 6'd1, 16'hFFFF, 1'b0}
  };

  localparam logic [ORDER_W-1:0] PHASE_ORDER [0:NUM_PHASES-1] = '{
    3'd5, 3'd0, 3'd7, 3'd1, 3'd2, 3'd6, 3'd3, 3'd4, 3'd5, 3'd2
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [ORDER_W-1:0]     cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tlast;

  buddy_block_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mirror of the block list
  logic [ORDER_W-1:0] blk_order [0:LIST_CAP-1];
  logic [OWNER_W-1:0] blk_owner [0:LIST_CAP-1];
  int unsigned        blk_total;
  logic [ORDER_W-1:0] mem_order;

  reply_t reply_q [$];

  int unsigned error_count   = 0;
  int unsigned req_count     = 0;
  int unsigned granted_count = 0;
  int unsigned refused_count = 0;
  int unsigned query_count   = 0;
  int unsigned beat_count    = 0;
  int unsigned cfg_count     = 0;
  int unsigned idle_cycles   = 0;
  bit          tx_no_gap     = 1'b0;
  bit          rx_no_stall   = 1'b0;

  function automatic void restart_list(logic [ORDER_W-1:0] wr_val);
    mem_order = (wr_val > 3'd5) ? 3'd5 : wr_val;
    blk_order[0] = mem_order;
    blk_owner[0] = '0;
    blk_total = 1;
  endfunction

  function automatic logic [ORDER_W-1:0] want_order(logic [SIZE_W-1:0] units);
    int unsigned k;
    k = 0;
    while (k < 7 && (1 << k) < units) k++;
    return k[ORDER_W-1:0];
  endfunction

  // first fit, split down to size, mark the owner
  function automatic void predict_alloc(logic [OWNER_W-1:0] owner,
                                        logic [SIZE_W-1:0] size, bit record);
    logic [ORDER_W-1:0] want;
    int unsigned        pos;
    bit                 hit;
    reply_t             r;
    want = want_order(size);
    hit = 1'b0;
    pos = 0;
    for (int unsigned i = 0; i < blk_total; i++) begin
      if (!hit && blk_owner[i] == '0 && blk_order[i] >= want) begin
        pos = i;
        hit = 1'b1;
      end
    end
    if (hit) begin
      while (blk_order[pos] > want && blk_total < LIST_CAP) begin
        for (int unsigned i = blk_total; i > pos + 1; i--) begin
          blk_order[i] = blk_order[i-1];
          blk_owner[i] = blk_owner[i-1];
        end
        blk_total++;
        blk_order[pos] = blk_order[pos] - 1'b1;
        blk_order[pos+1] = blk_order[pos];
        blk_owner[pos+1] = '0;
      end
      blk_owner[pos] = owner;
      granted_count++;
    end else begin
      refused_count++;
    end
    if (record) begin
      r = '{count: blk_total[COUNT_W-1:0], owner: owner, ok: hit, last: 1'b1};
      reply_q.push_back(r);
    end
  endfunction

  function automatic void predict_listing();
    reply_t r;
    for (int unsigned i = 0; i < blk_total; i++) begin
      r = '{count: blk_total[COUNT_W-1:0], owner: blk_owner[i], ok: 1'b1,
            last: (i + 1 == blk_total)};
      reply_q.push_back(r);
    end
  endfunction

  // hold the request stream idle until every result is back
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  task automatic write_total_order(logic [ORDER_W-1:0] val);
    drain_replies();
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    restart_list(val);
    cfg_count++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_request(logic act, logic [OWNER_W-1:0] owner,
                              logic [SIZE_W-1:0] size, bit typed, reply_t typed_r);
    int unsigned gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, size, owner};
    if (typed) reply_q.push_back(typed_r);
    if (act == ACT_ALLOC) begin
      predict_alloc(owner, size, !typed);
    end else begin
      query_count++;
      if (!typed) predict_listing();
    end
    do @(posedge clk_i); while (!s_axis_tready);
    req_count++;
  endtask

  task automatic random_request();
    int unsigned        pick;
    logic               act;
    logic [OWNER_W-1:0] own;
    logic [SIZE_W-1:0]  sz;
    pick = $urandom_range(0, 99);
    act  = ACT_ALLOC;
    own  = $urandom_range(1, 65535);
    sz   = $urandom_range(0, 63);
    if (pick < 14) begin
      act = ACT_QUERY;
    end else if (pick < 24) begin
      // noise: any size, sometimes owner zero
      if ($urandom_range(0, 3) == 0) own = '0;
    end else if (pick < 60) begin
      sz = $urandom_range(1, 4);
    end else begin
      sz = $urandom_range(1, 1 << mem_order);
    end
    send_request(act, own, sz, 1'b0, '0);
  endtask

  // result side: random stalls per beat, checked in order
  int unsigned rx_wait = 0;
  reply_t      got;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{count: m_axis_tdata[5:0], owner: m_axis_tdata[21:6],
              ok: m_axis_tdata[22], last: m_axis_tlast};
      beat_count++;
      if (reply_q.size() == 0) begin
        error_count++;
        $display("%0t: expected no result, got count=%0d owner=%h ok=%b last=%b",
                 $time, got.count, got.owner, got.ok, got.last);
      end else begin
        if (got !== reply_q[0]) begin
          error_count++;
          $display("%0t: mismatch exp count=%0d owner=%h ok=%b last=%b,",
                   $time, reply_q[0].count, reply_q[0].owner, reply_q[0].ok,
                   reply_q[0].last);
          $display("%0t:          got count=%0d owner=%h ok=%b last=%b",
                   $time, got.count, got.owner, got.ok, got.last);
        end
        void'(reply_q.pop_front());
      end
      rx_wait = rx_no_stall ? 0 : $urandom_range(0, 3);
    end
    if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ends the run if the block stops moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, reply_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    restart_list(3'd5);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned n = 0; n < NUM_ROWS; n++) begin
      case (DIRECTED[n].kind)
        ROW_CFG: begin
          write_total_order(DIRECTED[n].order);
        end
        default: begin
          send_request((DIRECTED[n].kind == ROW_QUERY) ? ACT_QUERY : ACT_ALLOC,
                       DIRECTED[n].owner, DIRECTED[n].size, DIRECTED[n].typed,
                       '{count: DIRECTED[n].t_count, owner: DIRECTED[n].t_owner,
                         ok: DIRECTED[n].t_ok, last: 1'b1});
        end
      endcase
    end

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      write_total_order(PHASE_ORDER[ph]);
      tx_no_gap   = (ph % 3 == 1);
      rx_no_stall = (ph % 4 == 2);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) drain_replies();
        random_request();
      end
    end

    drain_replies();
    repeat (END_SETTLE) @(posedge clk_i);

    $display("covered %0d requests: %0d allocations granted, %0d refused, %0d list queries",
             req_count, granted_count, refused_count, query_count);
    $display("checked %0d result beats across %0d order register writes",
             beat_count, cfg_count);
    if (error_count == 0 && reply_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_dp.sv
rtl/buddy_block_allocator.sv
tb/tb_buddy_block_allocator.sv
